@@ rtl/fsq_pkg.sv @@
// Shared types and constants for the floating-point square root block.
// Used by the controller, the datapath and the top level; no dependencies.
package fsq_pkg;

    localparam logic [1:0] PREC_HALF       = 2'd0;
    localparam logic [1:0] PREC_SINGLE     = 2'd1;
    localparam logic [1:0] PREC_DOUBLE     = 2'd2;
    // The spare precision code also selects double.
    localparam logic [1:0] PREC_DOUBLE_ALT = 2'd3;

    localparam logic [1:0] RND_NEAREST = 2'd0;
    localparam logic [1:0] RND_PLUS    = 2'd1;
    localparam logic [1:0] RND_MINUS   = 2'd2;
    localparam logic [1:0] RND_ZERO    = 2'd3;

    localparam logic [1:0] CFG_FTZ  = 2'd0;
    localparam logic [1:0] CFG_DNAN = 2'd1;
    localparam logic [1:0] CFG_RND  = 2'd2;

    localparam logic [7:0] FLAG_INVALID  = 8'h01;
    localparam logic [7:0] FLAG_INEXACT  = 8'h10;
    localparam logic [7:0] FLAG_INDENORM = 8'h80;

    localparam logic [63:0] DNAN_DOUBLE = 64'h7FF8000000000000;
    localparam logic [63:0] DNAN_SINGLE = 64'h0000_0000_7FC0_0000;
    localparam logic [63:0] DNAN_HALF   = 64'h0000_0000_0000_7E00;

    // Radicand register width: 2*(53+1) bits plus headroom for one pair.
    localparam int RAD_W  = 110;
    // Root grows to p+1 bits, at most 54.
    localparam int ROOT_W = 54;
    // Remainder is root width plus three bits.
    localparam int REM_W  = 57;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // unpack the operand and decide special cases
        logic norm;     // one left shift of a denormal significand
        logic prep;     // place the significand in the radicand register
        logic iter;     // one root bit
        logic fin;      // round and pack
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic special;  // result already known after unpacking
        logic normed;   // significand leading bit is set
        logic last;     // final root bit step is under way
    } t_stat;

endpackage

@@ rtl/fsq_ctrl.sv @@
// Controller state machine for the square root block.
// Depends on fsq_pkg; drives the datapath through t_cmd and reads t_stat.
module fsq_ctrl
    import fsq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_ITER = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.special) n_state = S_WAIT;
                else if (i_stat.normed) n_state = S_PREP;
                else n_state = S_NORM;
            end
            S_NORM: begin
                if (i_stat.normed) begin
                    n_state = S_PREP;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_stat.last) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/fsq_dp.sv @@
// Datapath for the square root block: unpack, normalize, digit recurrence,
// round and pack. Depends on fsq_pkg; sequenced by fsq_ctrl.
module fsq_dp
    import fsq_pkg::*;
(
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_operand,
    input  logic [1:0]  i_precision,
    input  logic        i_ftz,
    input  logic        i_dnan,
    input  logic [1:0]  i_rnd,
    output t_stat       o_stat,
    output logic [63:0] o_root_bits,
    output logic [7:0]  o_flags
);

    logic [52:0]       r_man;
    logic signed [12:0] r_exp;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [5:0]        r_cnt;
    logic              r_special;
    logic [63:0]       r_res;
    logic [7:0]        r_flags;
    logic [12:0]       r_biased;
    logic [1:0]        r_rnd_q;

    // Format decode.
    logic [5:0]  mbits;
    logic [5:0]  signpos;
    logic [10:0] emax;
    logic [10:0] bias;
    logic [63:0] defnan;
    logic [63:0] enc;
    logic        sgn;
    logic [10:0] expf;
    logic [51:0] man;
    logic [51:0] qbit;
    logic [51:0] mmask;

    always_comb begin
        case (i_precision)
            PREC_HALF: begin
                mbits = 6'd10; emax = 11'h1F; bias = 11'd15; defnan = DNAN_HALF;
                enc = {48'd0, i_operand[15:0]}; sgn = i_operand[15];
                signpos = 6'd15;
            end
            PREC_SINGLE: begin
                mbits = 6'd23; emax = 11'hFF; bias = 11'd127; defnan = DNAN_SINGLE;
                enc = {32'd0, i_operand[31:0]}; sgn = i_operand[31];
                signpos = 6'd31;
            end
            default: begin
                mbits = 6'd52; emax = 11'h7FF; bias = 11'd1023; defnan = DNAN_DOUBLE;
                enc = i_operand; sgn = i_operand[63];
                signpos = 6'd63;
            end
        endcase
        mmask = (52'd1 << mbits) - 52'd1;
        qbit  = 52'd1 << (mbits - 6'd1);
        expf  = 11'(enc >> mbits) & emax;
        man   = enc[51:0] & mmask;
    end

    // Per-item format constants held for the working phase.
    logic [5:0]  r_mbits;
    logic [10:0] r_emax;
    logic [10:0] r_bias;

    // Significand width p, shift count for the radicand and halved exponent.
    logic [5:0]  p;
    logic [6:0]  t_shift;
    logic signed [12:0] e_unb;
    logic signed [12:0] e_half;
    always_comb begin
        p     = r_mbits + 6'd1;
        e_unb = r_exp - 13'(r_mbits);
        t_shift = 7'(p) + 7'd1 + 7'(e_unb[0] ^ p[0] ^ 1'b1);
        e_half  = (e_unb - $signed({6'd0, t_shift})) >>> 1;
    end

    // One step of the restoring bit recurrence.
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // Rounding.
    logic [ROOT_W-1:0] q;
    logic [ROOT_W-1:0] q_inc;
    logic              rb;
    logic              st;
    logic              inc;
    logic              ovf;
    logic [12:0]       biased_f;
    logic [51:0]       frac_f;
    always_comb begin
        q   = r_root >> 1;
        rb  = r_root[0];
        st  = (r_rem != '0);
        if (r_rnd_q == RND_NEAREST)   inc = rb & (q[0] | st);
        else if (r_rnd_q == RND_PLUS) inc = rb | st;
        else                          inc = 1'b0;
        q_inc = q + ROOT_W'(inc);
        ovf   = q_inc[p];
        biased_f = r_biased + 13'(ovf);
        frac_f   = (ovf ? 52'(q_inc >> 1) : 52'(q_inc)) & ((52'd1 << r_mbits) - 52'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mbits   <= mbits;
            r_emax    <= emax;
            r_bias    <= bias;
            r_rnd_q   <= i_rnd;
            r_man     <= {1'b0, man} | (expf != 0 ? (53'd1 << mbits) : 53'd0);
            r_exp     <= (expf != 0) ? $signed({2'b0, expf}) - $signed({2'b0, bias})
                                     : 13'sd1 - $signed({2'b0, bias});
            if (expf == emax) begin
                r_special <= 1'b1;
                if (man == '0) begin
                    if (sgn) begin
                        r_res <= defnan; r_flags <= FLAG_INVALID;
                    end else begin
                        r_res <= enc; r_flags <= 8'd0;
                    end
                end else if ((man & qbit) != '0) begin
                    r_res   <= i_dnan ? defnan : enc;
                    r_flags <= 8'd0;
                end else begin
                    r_res   <= i_dnan ? defnan : (enc | 64'(qbit));
                    r_flags <= FLAG_INVALID;
                end
            end else if (expf == '0 && (man == '0 || i_ftz)) begin
                // A zero result keeps the operand's sign.
                r_special <= 1'b1;
                r_res     <= 64'(sgn) << signpos;
                r_flags   <= (man != '0 && i_precision != PREC_HALF) ? FLAG_INDENORM : 8'd0;
            end else if (sgn) begin
                r_special <= 1'b1;
                r_res <= defnan; r_flags <= FLAG_INVALID;
            end else begin
                r_special <= 1'b0;
                r_flags   <= 8'd0;
            end
        end
        if (i_cmd.norm) begin
            r_man <= r_man << 1;
            r_exp <= r_exp - 13'sd1;
        end
        if (i_cmd.prep) begin
            // Radicand m*2^t, top-aligned so that pair i=p sits at the top.
            r_rad    <= RAD_W'({57'd0, r_man} << t_shift) << (RAD_W - 2 * (7'(p) + 7'd1));
            r_rem    <= '0;
            r_root   <= '0;
            r_cnt    <= p;
            r_biased <= 13'(p) + e_half + 13'(r_bias);
        end
        if (i_cmd.iter) begin
            r_rad  <= r_rad << 2;
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_cnt  <= r_cnt - 6'd1;
        end
        if (i_cmd.fin) begin
            r_res   <= ((64'(biased_f[10:0] & r_emax)) << r_mbits) | 64'(frac_f);
            r_flags <= (rb | st) ? FLAG_INEXACT : 8'd0;
        end
    end

    assign o_stat.special = r_special;
    assign o_stat.normed  = r_man[r_mbits];
    assign o_stat.last    = (r_cnt == 6'd0);
    assign o_root_bits    = r_res;
    assign o_flags        = r_flags;

endmodule

@@ rtl/fp_sqrt_radix4_srt.sv @@
// Top level of the floating-point square root block.
// Depends on fsq_pkg, fsq_ctrl and fsq_dp.
//
// Iterative IEEE half/single/double square root with four rounding modes.
// One item at a time, one root bit per cycle. A special operand (zero, flushed
// denormal, infinity, NaN or negative) goes from the check state straight to
// the wait state, from which it is handed to the output register. Any other
// operand goes through the prepare, iterate and finish states first, taking
// 12, 25 or 54 root-bit steps for half, single and double. The next operand is
// accepted once the block has returned to idle. An unflushed denormal first
// passes the normalizing state, shifting it left until its leading bit is set.
// The result sits in an output register until taken; a finished result waits
// inside the block, and the input stays blocked, only while that register
// still holds an earlier result that has not been taken.
module fp_sqrt_radix4_srt
    import fsq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] operand
    input  logic [1:0]  s_axis_tuser,   // [1:0] precision
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] root_bits, [71:64] exception_flags
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    logic       r_ftz;
    logic       r_dnan;
    logic [1:0] r_rnd;
    logic       r_oval;
    logic [71:0] r_odata;

    t_cmd  cmd;
    t_stat stat;
    logic  busy;
    logic  done;
    logic [63:0] res;
    logic [7:0]  flg;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ftz  <= 1'b0;
            r_dnan <= 1'b0;
            r_rnd  <= RND_NEAREST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FTZ:  r_ftz  <= i_cfg_data[0];
                CFG_DNAN: r_dnan <= i_cfg_data[0];
                CFG_RND:  r_rnd  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !busy;

    fsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_axis_tvalid && s_axis_tready),
        .i_out_free (!r_oval || m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (done)
    );

    fsq_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_operand   (s_axis_tdata),
        .i_precision (s_axis_tuser),
        .i_ftz       (r_ftz),
        .i_dnan      (r_dnan),
        .i_rnd       (r_rnd),
        .o_stat      (stat),
        .o_root_bits (res),
        .o_flags     (flg)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (done) begin
            r_oval <= 1'b1;
        end else if (m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_odata <= {flg, res};
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

endmodule
